/* design/tdfa_pkg.sv */
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared codes and types of the table-driven automaton recognizer.
// ----------------------------------------------------------------------------
package tdfa_pkg;

  // request codes
  localparam logic [1:0] REQ_LOAD_TRANS = 2'd0;
  localparam logic [1:0] REQ_LOAD_SYM   = 2'd1;
  localparam logic [1:0] REQ_FEED       = 2'd2;
  localparam logic [1:0] REQ_END        = 2'd3;

  // status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_ACCEPTED = 3'd1;
  localparam logic [2:0] STATUS_REJECTED = 3'd2;
  localparam logic [2:0] STATUS_REFUSED  = 3'd3;
  localparam logic [2:0] STATUS_UNKNOWN  = 3'd4;

  // register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_INITIAL_STATE  = 2'd0;
  localparam logic [1:0] REG_STATE_COUNT    = 2'd1;
  localparam logic [1:0] REG_SYMBOL_COUNT   = 2'd2;
  localparam logic [1:0] REG_ACCEPTING_MASK = 2'd3;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  // reset values of the registers
  localparam logic [5:0]  RST_INITIAL_STATE = 6'd0;
  localparam logic [6:0]  RST_STATE_COUNT   = 7'd64;
  localparam logic [4:0]  RST_SYMBOL_COUNT  = 5'd16;
  localparam logic [63:0] RST_ACCEPT_MASK   = 64'd0;

  typedef struct packed {
    logic [5:0]  initial_state;
    logic [6:0]  state_count;
    logic [4:0]  symbol_count;
    logic [63:0] accepting_mask;
  } cfg_t;

  // alphabet search result
  typedef struct packed {
    logic       hit;
    logic [3:0] pos;
  } match_t;

endpackage

/* design/tdfa_ram.sv */
// ----------------------------------------------------------------------------
// tdfa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tdfa_alpha.sv */
// ----------------------------------------------------------------------------
// tdfa_alpha
// Alphabet store with a first-match search over the active entries.
// ----------------------------------------------------------------------------
module tdfa_alpha
  import tdfa_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int YW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [YW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [4:0]    symbol_count,
  input  logic [7:0]    char_code,
  output match_t        match
);

  logic [7:0] alpha [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      alpha[waddr] <= wdata;
    end
  end

  // lowest matching position wins
  always_comb begin
    match = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if ((5'(k) < symbol_count) && (alpha[k] == char_code)) begin
        match.hit = 1'b1;
        match.pos = 4'(k);
      end
    end
  end

endmodule

/* design/tdfa_regs.sv */
// ----------------------------------------------------------------------------
// tdfa_regs
// APB register bank holding the automaton configuration.
// ----------------------------------------------------------------------------
module tdfa_regs
  import tdfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_state  <= RST_INITIAL_STATE;
      cfg.state_count    <= RST_STATE_COUNT;
      cfg.symbol_count   <= RST_SYMBOL_COUNT;
      cfg.accepting_mask <= RST_ACCEPT_MASK;
    end else if (wr) begin
      unique case (idx)
        REG_INITIAL_STATE:  cfg.initial_state  <= pwdata[5:0];
        REG_STATE_COUNT:    cfg.state_count    <= pwdata[6:0];
        REG_SYMBOL_COUNT:   cfg.symbol_count   <= pwdata[4:0];
        REG_ACCEPTING_MASK: cfg.accepting_mask <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INITIAL_STATE:  prdata = 64'(cfg.initial_state);
      REG_STATE_COUNT:    prdata = 64'(cfg.state_count);
      REG_SYMBOL_COUNT:   prdata = 64'(cfg.symbol_count);
      REG_ACCEPTING_MASK: prdata = cfg.accepting_mask;
    endcase
  end

endmodule

/* design/table_driven_dfa_recognizer.sv */
// ----------------------------------------------------------------------------
// table_driven_dfa_recognizer
// Programmable deterministic finite automaton that accepts or rejects strings.
// ----------------------------------------------------------------------------
// Each input beat is one request: load a transition entry, load an alphabet
// character, feed one character of a string, or end the string; every request
// answers with exactly one output beat carrying the state after the request
// and a status. Load and end requests write their result on acceptance. In a
// feed, the accept cycle matches the character against the alphabet and issues
// the transition RAM address {state, symbol}; then, once the output register
// is free, the registered RAM data becomes the new state. That RAM read in the
// state loop sets the feed rate. A new request is taken once the previous
// one has produced its result and the output register is free or being
// emptied. The transition table and the alphabet have no reset and no
// clearing pass: an entry must be written before a string can reach it.
// Configuration (initial state, state count, alphabet size, accepting mask)
// sits on an APB port with 64-bit data at byte addresses 0, 8, 16 and 24; the
// user must write it only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module table_driven_dfa_recognizer
  import tdfa_pkg::*;
#(
  parameter int MAX_STATES  = 64,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [5:0]         state_index,
  input  logic [3:0]         symbol_index,
  input  logic [5:0]         next_state,
  input  logic [7:0]         char_code,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         current_state,
  output logic [2:0]         status
);

  // state bits, live alphabet entries (the 4-bit symbol field holds 16 entries at most)
  localparam int SW          = $clog2(MAX_STATES);
  localparam int ALPHA_DEPTH = (MAX_SYMBOLS < 16) ? MAX_SYMBOLS : 16;
  localparam int YW          = (ALPHA_DEPTH > 1) ? $clog2(ALPHA_DEPTH) : 1;
  localparam int TW          = SW + YW;
  localparam int TDEPTH      = 1 << TW;
  localparam logic [6:0] MAX_STATES_7 = 7'(MAX_STATES);

  // sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  cfg_t   cfg;
  match_t match;

  logic       seq;            // sequencer state
  logic [5:0] present_state;
  logic       walk_stopped;
  logic       string_fresh;

  // feed in flight
  logic [5:0] f_state;
  logic       f_stopped;
  logic       f_hit;
  logic       f_inrange;

  logic          in_accept;
  logic          out_free;
  logic          finish;
  logic [5:0]    visible;
  logic [6:0]    state_limit;
  logic          trans_refused;
  logic          sym_refused;
  logic          ram_we;
  logic          ram_re;
  logic          alpha_we;
  logic [TW-1:0] ram_waddr;
  logic [TW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  tdfa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: the output register parts the two channels
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (seq == ST_READ) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign finish    = (seq == ST_READ) && out_free;

  // a fresh string sits in the initial state until its first feed
  assign visible = string_fresh ? cfg.initial_state : present_state;

  // load checks
  assign state_limit   = (cfg.state_count < MAX_STATES_7) ? cfg.state_count : MAX_STATES_7;
  assign sym_refused   = 32'(symbol_index) >= MAX_SYMBOLS;
  assign trans_refused = ({1'b0, next_state} >= state_limit)
                      || (32'(state_index) >= MAX_STATES) || sym_refused;

  assign ram_we    = in_accept && (req_type == REQ_LOAD_TRANS) && !trans_refused;
  assign alpha_we  = in_accept && (req_type == REQ_LOAD_SYM) && !sym_refused;
  assign ram_re    = in_accept && (req_type == REQ_FEED);
  assign ram_waddr = {state_index[SW-1:0], symbol_index[YW-1:0]};
  assign ram_raddr = {visible[SW-1:0], match.pos[YW-1:0]};

  tdfa_alpha #(
    .DEPTH (ALPHA_DEPTH),
    .YW    (YW)
  ) u_alpha (
    .clk          (clk),
    .we           (alpha_we),
    .waddr        (symbol_index[YW-1:0]),
    .wdata        (char_code),
    .symbol_count (cfg.symbol_count),
    .char_code    (char_code),
    .match        (match)
  );

  // transition table, entry {state, symbol}
  tdfa_ram #(
    .WIDTH (SW),
    .DEPTH (TDEPTH)
  ) u_trans (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (next_state[SW-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // feed context held across the RAM read
  always_ff @(posedge clk) begin
    if (ram_re) begin
      f_state   <= visible;
      f_stopped <= walk_stopped;
      f_hit     <= match.hit;
      f_inrange <= 32'(visible) < MAX_STATES;
    end
  end

  // sequencer and automaton control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= ST_IDLE;
      present_state <= '0;
      walk_stopped  <= 1'b0;
      string_fresh  <= 1'b1;
    end else begin
      if (in_accept) begin
        unique case (req_type)
          REQ_LOAD_TRANS, REQ_LOAD_SYM: begin
          end
          REQ_FEED: begin
            seq           <= ST_READ;
            present_state <= visible;
            string_fresh  <= 1'b0;
          end
          REQ_END: begin
            present_state <= cfg.initial_state;
            walk_stopped  <= 1'b0;
            string_fresh  <= 1'b1;
          end
        endcase
      end
      if (finish) begin
        seq <= ST_IDLE;
        // unknown character stops the walk; out-of-range states stay put
        if (!f_stopped && !f_hit) begin
          walk_stopped <= 1'b1;
        end else if (!f_stopped && f_inrange) begin
          present_state <= 6'(ram_rdata);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && (req_type != REQ_FEED)) begin
      out_valid <= 1'b1;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      unique case (req_type)
        REQ_LOAD_TRANS: begin
          current_state <= visible;
          status        <= trans_refused ? STATUS_REFUSED : STATUS_OK;
        end
        REQ_LOAD_SYM: begin
          current_state <= visible;
          status        <= sym_refused ? STATUS_REFUSED : STATUS_OK;
        end
        REQ_FEED: begin
        end
        REQ_END: begin
          current_state <= visible;
          status        <= (!walk_stopped && cfg.accepting_mask[visible])
                           ? STATUS_ACCEPTED : STATUS_REJECTED;
        end
      endcase
    end else if (finish) begin
      if (f_stopped || !f_hit) begin
        current_state <= f_state;
        status        <= STATUS_UNKNOWN;
      end else if (f_inrange) begin
        current_state <= 6'(ram_rdata);
        status        <= STATUS_OK;
      end else begin
        current_state <= f_state;
        status        <= STATUS_OK;
      end
    end
  end

endmodule

/* design/tdfa_checker.sv */
// ----------------------------------------------------------------------------
// tdfa_checker
// Port-level checks of the recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module tdfa_checker
  import tdfa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] req_type,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] current_state,
  input logic [2:0] status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(current_state) && $stable(status))
    else $error("result beat changed while stalled");

  // a feed stalls the request channel while its table read is in flight
  a_feed_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_FEED) |=> in_stall)
    else $error("request taken during a feed table read");

  // results only follow accepted requests
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall) || $past(in_valid && !in_stall, 2))
    else $error("result beat without a request");

  // an end request always answers with accepted or rejected
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_END)
    |=> out_valid && (status == STATUS_ACCEPTED || status == STATUS_REJECTED))
    else $error("end of string without a verdict");

endmodule

bind table_driven_dfa_recognizer tdfa_checker u_tdfa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .req_type      (req_type),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .current_state (current_state),
  .status        (status)
);
